FILE: rtl/core/bhw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery health window estimator package
// Shared widths, codes, reset values, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bhw_pkg;

  localparam int HOUR_W   = 5;
  localparam int CHARGE_W = 10;
  localparam int CAP_W    = 14;
  localparam int LOAD_W   = 14;
  localparam int HEALTH_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // hours * load, drop * capacity, and the scaled numerator.
  localparam int HL_W  = HOUR_W + LOAD_W;
  localparam int DEN_W = CHARGE_W + CAP_W;
  localparam int NUM_W = 36;
  localparam int QUO_W = HEALTH_W + 1;

  localparam int DIV_STEPS = NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [16:0]         HEALTH_SCALE = 17'd100000;
  localparam logic [QUO_W-1:0]    HEALTH_CAP   = QUO_W'(1000);
  localparam logic [HOUR_W-1:0]   HOUR_NONE    = 5'd31;
  localparam logic [HOUR_W-1:0]   HOURS_PER_DAY = 5'd24;

  localparam logic [HOUR_W-1:0]   START_HOUR_RST = 5'd22;
  localparam logic [HOUR_W-1:0]   END_HOUR_RST   = 5'd4;
  localparam logic [CAP_W-1:0]    CAPACITY_RST   = 14'd180;
  localparam logic [LOAD_W-1:0]   LOAD_RST       = 14'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_START_HOUR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_HOUR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD       = 2'd3;

  typedef enum logic [1:0] {
    STAT_WAITING   = 2'd0,
    STAT_MEASURING = 2'd1,
    STAT_VOIDED    = 2'd2,
    STAT_MEASURED  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_FIN,
    S_PUT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic eval;
    logic mul1;
    logic mul2;
    logic div_step;
    logic finish;
    logic load_out;
  } bhw_cmd_t;

  typedef struct packed {
    logic need_calc;
    logic zero_term;
  } bhw_sts_t;

  // Hours in the window, (end + 48 - start) mod 24, for any 5-bit registers.
  function automatic logic [HOUR_W-1:0] window_hours(input logic [HOUR_W-1:0] end_h,
                                                    input logic [HOUR_W-1:0] start_h);
    logic [6:0] t;
    t = {2'b00, end_h} + 7'd48 - {2'b00, start_h};
    for (int i = 0; i < 3; i++) begin
      if (t >= {2'b00, HOURS_PER_DAY}) begin
        t = t - {2'b00, HOURS_PER_DAY};
      end
    end
    return t[HOUR_W-1:0];
  endfunction

endpackage

FILE: rtl/core/bhw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery health window estimator controller
// Sequences one tick through evaluation, the optional health computation and
// the output register, and owns the in and out handshakes and the divide count.
// ----------------------------------------------------------------------------
module bhw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bhw_pkg::bhw_sts_t sts,
  output bhw_pkg::bhw_cmd_t cmd
);
  import bhw_pkg::*;

  state_t               state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 out_free;
  logic                 div_last;

  assign out_free = !out_valid_r || out_ready;
  assign div_last = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EVAL;
      S_EVAL: state_nxt = sts.need_calc ? S_MUL1 : S_PUT;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = sts.zero_term ? S_PUT : S_DIV;
      S_DIV:  if (div_last) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_PUT;
      S_PUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_EVAL: cmd.eval     = 1'b1;
      S_MUL1: cmd.mul1     = 1'b1;
      S_MUL2: cmd.mul2     = 1'b1;
      S_DIV:  cmd.div_step = 1'b1;
      S_FIN:  cmd.finish   = 1'b1;
      S_PUT:  cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    div_cnt_nxt = div_cnt_r;
    if (cmd.mul2) begin
      div_cnt_nxt = '0;
    end else if (cmd.div_step) begin
      div_cnt_nxt = div_cnt_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/core/bhw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery health window estimator datapath
// Configuration registers, window state, the two multiply stages, a
// restoring divider with a saturating quotient, and the output register.
// ----------------------------------------------------------------------------
module bhw_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bhw_pkg::bhw_cmd_t               cmd,
  output bhw_pkg::bhw_sts_t               sts,
  input  logic                            cfg_we,
  input  logic [bhw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bhw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_time_known,
  input  logic [bhw_pkg::HOUR_W-1:0]      in_hour_of_day,
  input  logic                            in_charge_valid,
  input  logic [bhw_pkg::CHARGE_W-1:0]    in_charge_tenths,
  input  logic                            in_irrigating,
  output logic [1:0]                      out_status,
  output logic [bhw_pkg::HEALTH_W-1:0]    out_health_tenths,
  output logic                            out_health_known
);
  import bhw_pkg::*;

  // Configuration
  logic [HOUR_W-1:0] start_hour_r;
  logic [HOUR_W-1:0] end_hour_r;
  logic [CAP_W-1:0]  capacity_r;
  logic [LOAD_W-1:0] load_r;

  // Latched transaction
  logic                lat_tk_r;
  logic [HOUR_W-1:0]   lat_hour_r;
  logic                lat_chg_ok_r;
  logic [CHARGE_W-1:0] lat_chg_r;
  logic                lat_irr_r;

  // Window state
  logic [HOUR_W-1:0]   prev_hour_r, prev_hour_nxt;
  logic                in_window_r, in_window_nxt;
  logic                spoiled_r, spoiled_nxt;
  logic [CHARGE_W-1:0] charge_open_r, charge_open_nxt;
  status_t             status_r, status_nxt;
  logic [HEALTH_W-1:0] health_r, health_nxt;
  logic                health_seen_r, health_seen_nxt;

  // Arithmetic
  logic [HL_W-1:0]    hl_r;
  logic [DEN_W-1:0]   den_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   rem_r;
  logic [QUO_W-1:0]   quo_r;
  logic               quo_ovf_r;
  logic [DEN_W:0]     partial;
  logic [DEN_W+1:0]   trial;
  logic [CHARGE_W-1:0] drop;
  logic               spoil_acc;
  logic               is_close;
  logic               close_void;

  // Output register
  status_t             out_status_r;
  logic [HEALTH_W-1:0] out_health_r;
  logic                out_known_r;

  assign spoil_acc  = spoiled_r | (in_window_r & lat_irr_r);
  assign is_close   = lat_tk_r && (lat_hour_r != prev_hour_r) &&
                      (lat_hour_r != start_hour_r) && (lat_hour_r == end_hour_r) &&
                      in_window_r;
  assign close_void = spoil_acc || !lat_chg_ok_r || (lat_chg_r >= charge_open_r);
  assign drop       = charge_open_r - lat_chg_r;

  assign sts.need_calc = is_close && !close_void;
  assign sts.zero_term = (hl_r == '0) || (den_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_hour_r <= START_HOUR_RST;
      end_hour_r   <= END_HOUR_RST;
      capacity_r   <= CAPACITY_RST;
      load_r       <= LOAD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_HOUR: start_hour_r <= cfg_data[HOUR_W-1:0];
        CFG_END_HOUR:   end_hour_r   <= cfg_data[HOUR_W-1:0];
        CFG_CAPACITY:   capacity_r   <= cfg_data[CAP_W-1:0];
        CFG_LOAD:       load_r       <= cfg_data[LOAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_hour_r   <= HOUR_NONE;
      in_window_r   <= 1'b0;
      spoiled_r     <= 1'b0;
      charge_open_r <= '0;
      status_r      <= STAT_WAITING;
      health_r      <= '0;
      health_seen_r <= 1'b0;
    end else begin
      prev_hour_r   <= prev_hour_nxt;
      in_window_r   <= in_window_nxt;
      spoiled_r     <= spoiled_nxt;
      charge_open_r <= charge_open_nxt;
      status_r      <= status_nxt;
      health_r      <= health_nxt;
      health_seen_r <= health_seen_nxt;
    end
  end

  always_comb begin
    prev_hour_nxt   = prev_hour_r;
    in_window_nxt   = in_window_r;
    spoiled_nxt     = spoiled_r;
    charge_open_nxt = charge_open_r;
    status_nxt      = status_r;
    health_nxt      = health_r;
    health_seen_nxt = health_seen_r;
    if (cmd.eval) begin
      if (!lat_tk_r) begin
        status_nxt = STAT_WAITING;
      end else begin
        spoiled_nxt = spoil_acc;
        if (lat_hour_r != prev_hour_r) begin
          prev_hour_nxt = lat_hour_r;
          // The start hour takes priority when start and end hours coincide.
          if (lat_hour_r == start_hour_r) begin
            if (lat_chg_ok_r) begin
              charge_open_nxt = lat_chg_r;
              in_window_nxt   = 1'b1;
              spoiled_nxt     = lat_irr_r;
              status_nxt      = STAT_MEASURING;
            end else begin
              status_nxt = STAT_WAITING;
            end
          end else if (is_close) begin
            in_window_nxt = 1'b0;
            if (close_void) begin
              status_nxt = STAT_VOIDED;
            end
          end
        end
      end
    end
    if (cmd.mul2 && sts.zero_term) begin
      status_nxt = STAT_VOIDED;
    end
    if (cmd.finish) begin
      health_nxt      = (quo_ovf_r || (quo_r > HEALTH_CAP)) ? HEALTH_CAP[HEALTH_W-1:0]
                                                             : quo_r[HEALTH_W-1:0];
      health_seen_nxt = 1'b1;
      status_nxt      = STAT_MEASURED;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      lat_tk_r     <= in_time_known;
      lat_hour_r   <= in_hour_of_day;
      lat_chg_ok_r <= in_charge_valid;
      lat_chg_r    <= in_charge_tenths;
      lat_irr_r    <= in_irrigating;
    end
  end

  // Restoring division: one quotient bit per cycle, MSB of the numerator first.
  assign partial = {rem_r, num_r[NUM_W-1]};
  assign trial   = {1'b0, partial} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      hl_r  <= HL_W'(window_hours(end_hour_r, start_hour_r)) * HL_W'(load_r);
      den_r <= DEN_W'(drop) * DEN_W'(capacity_r);
    end
    if (cmd.mul2) begin
      num_r     <= NUM_W'(hl_r) * NUM_W'(HEALTH_SCALE);
      rem_r     <= '0;
      quo_r     <= '0;
      quo_ovf_r <= 1'b0;
    end
    if (cmd.div_step) begin
      num_r     <= {num_r[NUM_W-2:0], 1'b0};
      quo_ovf_r <= quo_ovf_r | quo_r[QUO_W-1];
      if (!trial[DEN_W+1]) begin
        rem_r <= trial[DEN_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= partial[DEN_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_health_r <= health_r;
      out_known_r  <= health_seen_r;
    end
  end

  assign out_status        = out_status_r;
  assign out_health_tenths = out_health_r;
  assign out_health_known  = out_known_r;

endmodule

FILE: rtl/core/battery_health_window_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery health window estimator
// Tracks an overnight measuring window per polling tick and computes battery
// health in tenths of a percent when the window closes.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | time_known, hour_of_day, charge_valid,
//           |                      | charge_tenths, irrigating
//   out     | out_valid / out_ready| status, health_tenths, health_known
//   cfg     | cfg_valid / cfg_ready| cfg_index (0..3), cfg_data
//
// A tick runs from acceptance through evaluation to the output register; when
// the window closes with a valid drop it also runs two multiply stages, the
// one-bit-per-cycle divider and a capping step (no divide if a term is zero).
// One tick is in flight at a time; the next is accepted as soon as the
// previous result sits in the output register, even if it is not yet taken.
// A stalled output holds the block in its final step until out_ready.
// Synchronous reset restores the register defaults; cfg_ready is always high.
// ----------------------------------------------------------------------------
module battery_health_window_estimator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_time_known,
  input  logic [bhw_pkg::HOUR_W-1:0]      in_hour_of_day,
  input  logic                            in_charge_valid,
  input  logic [bhw_pkg::CHARGE_W-1:0]    in_charge_tenths,
  input  logic                            in_irrigating,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [bhw_pkg::HEALTH_W-1:0]    out_health_tenths,
  output logic                            out_health_known,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bhw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bhw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bhw_pkg::*;

  bhw_cmd_t cmd;
  bhw_sts_t sts;

  assign cfg_ready = 1'b1;

  bhw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bhw_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_time_known     (in_time_known),
    .in_hour_of_day    (in_hour_of_day),
    .in_charge_valid   (in_charge_valid),
    .in_charge_tenths  (in_charge_tenths),
    .in_irrigating     (in_irrigating),
    .out_status        (out_status),
    .out_health_tenths (out_health_tenths),
    .out_health_known  (out_health_known)
  );

  // Only one tick is in flight: acceptance closes the input until it is done.
  a_single_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a tick is in flight");

  a_health_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_health_tenths <= HEALTH_CAP[HEALTH_W-1:0])
    else $error("health exceeds its cap");

  a_measured_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_MEASURED |-> out_health_known)
    else $error("measured status without a known health figure");

  a_divide_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !in_ready && !cmd.load_out)
    else $error("divider running outside of a computation");

endmodule
